### src/skt_pkg.sv
// Shared types and codes for the sorted key/id table.
// Used by skt_ctrl, skt_datapath and sorted_key_id_table_core.
`timescale 1ns / 1ps
package skt_pkg;

	localparam int ID_W     = 31;
	localparam int STATUS_W = 3;
	localparam int OUT_CNT_W = 9;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_NOT_FOUND   = 3'd1,
		ST_EXISTS      = 3'd2,
		ST_FULL        = 3'd3,
		ST_ID_MISMATCH = 3'd4
	} status_t;

	typedef struct packed {
		logic                load_req;
		logic                srch_rd;
		logic                srch_cmp;
		logic                j_load_count;
		logic                sh_rd;
		logic                sh_wr;
		logic                ins_wr;
		logic                dec_count;
		logic                set_status;
		logic [STATUS_W-1:0] res;
		logic                out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       lo_lt_hi;
		logic       hit;
		logic       id_match;
		logic       full;
		logic       more;
		logic       out_busy;
	} dp_sts_t;

endpackage

### src/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

### src/skt_datapath.sv
// Datapath of the sorted key/id table: request registers, search bounds,
// shift pointer, entry count, result register and the entry RAM.
// Depends on skt_pkg and skt_ram.
`timescale 1ns / 1ps
module skt_datapath #(
	parameter int CAPACITY  = 256,
	parameter int KEY_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  skt_pkg::dp_cmd_t           cmd,
	output skt_pkg::dp_sts_t           sts,
	input  logic [1:0]                 req_type,
	input  logic [63:0]                key,
	input  logic [skt_pkg::ID_W-1:0]   entry_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [skt_pkg::STATUS_W-1:0] status,
	output logic [skt_pkg::ID_W-1:0]   found_id,
	output logic [skt_pkg::OUT_CNT_W-1:0] entry_count
);
	import skt_pkg::*;

	localparam int KEY_W  = 8 * KEY_BYTES;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int ENT_W  = KEY_W + ID_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]   id_q;
	logic [CNT_W-1:0]  lo_q, hi_q, mid_q, j_q, count_q;
	logic [STATUS_W-1:0] res_q;
	logic [ID_W-1:0]   found_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]   out_found_q;
	logic [OUT_CNT_W-1:0] out_count_q;

	logic [CNT_W:0]    sum_c;
	logic [CNT_W-1:0]  mid_c, src_c;
	logic [ENT_W-1:0]  rd_data, wr_data;
	logic [KEY_W-1:0]  rd_key;
	logic [ID_W-1:0]   rd_id;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              wr_en, is_add;

	assign sum_c   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c   = sum_c[CNT_W:1];
	assign is_add  = (op_q == OP_ADD);
	assign src_c   = is_add ? (j_q - ONE_C) : (j_q + ONE_C);
	assign rd_key  = rd_data[ENT_W-1:ID_W];
	assign rd_id   = rd_data[ID_W-1:0];
	assign rd_addr = cmd.srch_rd ? mid_c[ADDR_W-1:0] : src_c[ADDR_W-1:0];
	assign wr_addr = j_q[ADDR_W-1:0];
	assign wr_en   = cmd.sh_wr | cmd.ins_wr;
	assign wr_data = cmd.ins_wr ? {key_q, id_q} : rd_data;

	skt_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= req_type;
			key_q <= key[KEY_W-1:0];
			id_q  <= entry_id;
			lo_q  <= '0;
			hi_q  <= count_q;
		end
		if (cmd.srch_rd) begin
			mid_q <= mid_c;
		end
		if (cmd.srch_cmp) begin
			if (rd_key < key_q) begin
				lo_q <= mid_q + ONE_C;
			end else begin
				hi_q <= mid_q;
			end
			j_q <= mid_q;
		end
		if (cmd.j_load_count) begin
			j_q <= count_q;
		end
		if (cmd.sh_wr) begin
			j_q <= src_c;
		end
		if (cmd.set_status) begin
			res_q <= cmd.res;
		end
		if (cmd.out_load) begin
			out_status_q <= res_q;
			out_found_q  <= found_q;
			out_count_q  <= OUT_CNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				found_q <= '0;
			end else if (cmd.srch_cmp && rd_key == key_q && op_q == OP_LOOKUP) begin
				found_q <= rd_id;
			end
			if (cmd.ins_wr) begin
				count_q <= count_q + ONE_C;
			end else if (cmd.dec_count) begin
				count_q <= count_q - ONE_C;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op       = op_q;
		sts.lo_lt_hi = (lo_q < hi_q);
		sts.hit      = (rd_key == key_q);
		sts.id_match = (rd_id == id_q);
		sts.full     = (count_q >= CAP_C);
		sts.more     = is_add ? (j_q > lo_q) : ((j_q + ONE_C) < count_q);
		sts.out_busy = out_valid_q & ~out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found_id    = out_found_q;
	assign entry_count = out_count_q;

`ifndef SYNTH
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C) else $error("entry count above capacity");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sh_wr |-> $past(cmd.sh_rd)) else $error("shift write without read");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> count_q < CAP_C) else $error("insert into full table");
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.srch_rd && lo_q < hi_q) |-> mid_c < count_q)
		else $error("search probe beyond count");
`endif
endmodule

### src/skt_ctrl.sv
// Controller of the sorted key/id table: binary search, shift sweep and
// result handoff sequencing. Depends on skt_pkg.
`timescale 1ns / 1ps
module skt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  skt_pkg::dp_sts_t sts,
	output skt_pkg::dp_cmd_t cmd
);
	import skt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_SRCH_ADDR = 8'b0000_0010,
		S_SRCH_CMP  = 8'b0000_0100,
		S_SH_CHK    = 8'b0000_1000,
		S_SH_RD     = 8'b0001_0000,
		S_SH_WR     = 8'b0010_0000,
		S_INS_WR    = 8'b0100_0000,
		S_DONE      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_SRCH_ADDR;
				end
			end
			S_SRCH_ADDR: begin
				if (sts.op != OP_LOOKUP && sts.op != OP_ADD && sts.op != OP_REMOVE) begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_OK;
					state_d        = S_DONE;
				end else if (sts.lo_lt_hi) begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SRCH_CMP;
				end else if (sts.op == OP_ADD) begin
					if (sts.full) begin
						cmd.set_status = 1'b1;
						cmd.res        = ST_FULL;
						state_d        = S_DONE;
					end else begin
						cmd.j_load_count = 1'b1;
						cmd.set_status   = 1'b1;
						cmd.res          = ST_OK;
						state_d          = S_SH_CHK;
					end
				end else begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_NOT_FOUND;
					state_d        = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				if (!sts.hit) begin
					state_d = S_SRCH_ADDR;
				end else if (sts.op == OP_LOOKUP) begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_OK;
					state_d        = S_DONE;
				end else if (sts.op == OP_ADD) begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_EXISTS;
					state_d        = S_DONE;
				end else if (sts.id_match) begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_OK;
					state_d        = S_SH_CHK;
				end else begin
					cmd.set_status = 1'b1;
					cmd.res        = ST_ID_MISMATCH;
					state_d        = S_DONE;
				end
			end
			S_SH_CHK: begin
				if (sts.more) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end else if (sts.op == OP_ADD) begin
					state_d = S_INS_WR;
				end else begin
					cmd.dec_count = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_SH_RD: begin
				cmd.sh_rd = 1'b1;
				state_d   = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_CHK;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_SRCH_ADDR) else $error("beat not taken");
	a_wr_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SH_WR |-> $past(state_q) == S_SH_CHK) else $error("bad shift order");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && sts.out_busy) |=> state_q == S_DONE)
		else $error("result dropped");
`endif
endmodule

### src/sorted_key_id_table_core.sv
// Sorted key/id table: ordered table of keys with ids, lookup/add/remove.
// Top level; depends on skt_pkg, skt_ctrl, skt_datapath and skt_ram.
//
// Input channel (in_valid/in_ready) carries one request beat: req_type,
// key and entry_id. Output channel (out_valid/out_ready) returns one beat
// per request: status, found_id and entry_count after the request.
// Requests are processed one at a time. Each binary-search probe addresses
// the RAM, then compares on the registered read data; at most
// ceil(log2(CAPACITY+1)) probes. Add and remove then move one entry at a
// time (read, then write) through the single-port-write entry RAM, up to
// CAPACITY-1 moves. The next request can be taken in the same cycle that
// out_valid rises. A finished beat waits in the output register; the next
// request is taken meanwhile, and only its result waits while the receiver
// stalls. Reset empties the table at once (count to zero); the RAM is not
// cleared.
`timescale 1ns / 1ps
module sorted_key_id_table_core #(
	parameter int CAPACITY  = 256,
	parameter int KEY_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [63:0]                   key,
	input  logic [skt_pkg::ID_W-1:0]      entry_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skt_pkg::STATUS_W-1:0]  status,
	output logic [skt_pkg::ID_W-1:0]      found_id,
	output logic [skt_pkg::OUT_CNT_W-1:0] entry_count
);
	import skt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skt_datapath #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.key         (key),
		.entry_id    (entry_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_id    (found_id),
		.entry_count (entry_count)
	);
endmodule

### test/skt_checker.sv
// Checker for sorted_key_id_table_core: watches both channels, keeps its own
// ordered key/id table, predicts each result beat and compares it.
// Depends on skt_pkg.
`timescale 1ns / 1ps
module skt_checker #(
	parameter int CAPACITY  = 256,
	parameter int KEY_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [63:0]                   key,
	input  logic [skt_pkg::ID_W-1:0]      entry_id,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [skt_pkg::STATUS_W-1:0]  status,
	input  logic [skt_pkg::ID_W-1:0]      found_id,
	input  logic [skt_pkg::OUT_CNT_W-1:0] entry_count,
	output int                            fail_count,
	output int                            pending
);
	import skt_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]  st;
		logic [ID_W-1:0]      fid;
		logic [OUT_CNT_W-1:0] cnt;
	} result_t;

	logic [63:0]     tbl_key [CAPACITY];
	logic [ID_W-1:0] tbl_id  [CAPACITY];
	int              tbl_count;
	result_t         result_q[$];

	assign pending = result_q.size();

	function automatic logic [63:0] key_mask();
		return {64{1'b1}} >> (64 - 8 * KEY_BYTES);
	endfunction

	function automatic bit find_slot(input logic [63:0] k, output int pos);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_key[mid] == k) begin
				pos = mid;
				return 1;
			end
			if (tbl_key[mid] < k) lo = mid + 1;
			else hi = mid;
		end
		pos = lo;
		return 0;
	endfunction

	function automatic result_t apply_request(input logic [1:0] op, input logic [63:0] kin,
			input logic [ID_W-1:0] id);
		result_t r;
		logic [63:0] k;
		int pos;
		bit hit;
		k = kin & key_mask();
		r = '0;
		hit = find_slot(k, pos);
		if (op == OP_LOOKUP) begin
			if (hit) r.fid = tbl_id[pos];
			else r.st = ST_NOT_FOUND;
		end else if (op == OP_ADD) begin
			if (hit) r.st = ST_EXISTS;
			else if (tbl_count >= CAPACITY) r.st = ST_FULL;
			else begin
				for (int j = tbl_count; j > pos; j--) begin
					tbl_key[j] = tbl_key[j-1];
					tbl_id[j] = tbl_id[j-1];
				end
				tbl_key[pos] = k;
				tbl_id[pos] = id;
				tbl_count++;
			end
		end else if (op == OP_REMOVE) begin
			if (!hit) r.st = ST_NOT_FOUND;
			else if (tbl_id[pos] != id) r.st = ST_ID_MISMATCH;
			else begin
				for (int j = pos; j + 1 < tbl_count; j++) begin
					tbl_key[j] = tbl_key[j+1];
					tbl_id[j] = tbl_id[j+1];
				end
				tbl_count--;
			end
		end
		r.cnt = tbl_count[OUT_CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			tbl_count = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (in_valid && in_ready)
				result_q.push_back(apply_request(req_type, key, entry_id));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected beat: st=%0d id=%0d cnt=%0d",
							status, found_id, entry_count);
				end else begin
					e = result_q.pop_front();
					if (e.st !== status || e.fid !== found_id || e.cnt !== entry_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp st=%0d id=%0d cnt=%0d got st=%0d id=%0d cnt=%0d",
								e.st, e.fid, e.cnt, status, found_id, entry_count);
					end
				end
			end
		end
	end
endmodule

### test/tb_sorted_key_id_table_core.sv
// Testbench top for sorted_key_id_table_core: drives requests and stalls,
// gives the verdict. Depends on skt_pkg, skt_checker and the block.
`timescale 1ns / 1ps
module tb_sorted_key_id_table_core;
	import skt_pkg::*;

	localparam int CAPACITY = 256;
	localparam int IDLE_LIMIT = 20000;

	logic                 clk = 0;
	logic                 arst_n = 1;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic [1:0]           req_type = 0;
	logic [63:0]          key = 0;
	logic [ID_W-1:0]      entry_id = 0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic [STATUS_W-1:0]  status;
	logic [ID_W-1:0]      found_id;
	logic [OUT_CNT_W-1:0] entry_count;
	int                   fail_count;
	int                   pending;
	int                   idle_cycles = 0;
	logic [63:0]          key_pool[$];
	logic [ID_W-1:0]      id_pool[$];

	always #5 clk = ~clk;

	sorted_key_id_table_core #(.CAPACITY(CAPACITY), .KEY_BYTES(8)) dut (.*);

	skt_checker #(.CAPACITY(CAPACITY), .KEY_BYTES(8)) chk (.*);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall before each beat
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 18);
			if (w > 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send(input logic [1:0] op, input logic [63:0] k, input logic [ID_W-1:0] id);
		int w;
		w = $urandom_range(0, 18);
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= op;
		key <= k;
		entry_id <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] k;
		logic [ID_W-1:0] id;
		logic [63:0] fill_key [CAPACITY];
		int r;
		int idx;
		arst_n <= 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, extremes, every status except full
		send(OP_LOOKUP, 64'd0, '0);
		send(OP_REMOVE, '1, '0);
		send(OP_ADD, 64'd0, '0);
		send(OP_ADD, '1, '1);
		send(OP_ADD, 64'h8000_0000_0000_0000, 31'h2AAA_AAAA);
		send(OP_ADD, 64'd0, ID_W'(5));
		send(OP_LOOKUP, 64'd0, '0);
		send(OP_LOOKUP, '1, '0);
		send(OP_LOOKUP, 64'h1234, '0);
		send(OP_REMOVE, 64'h8000_0000_0000_0000, 31'h5555_5555);
		send(OP_REMOVE, 64'h8000_0000_0000_0000, 31'h2AAA_AAAA);
		send(2'd3, 64'h5555_5555_5555_5555, '1);
		send(OP_REMOVE, '1, '1);
		send(OP_REMOVE, 64'd0, '0);
		drain();

		// fill to capacity, then hit the full case
		for (int i = 0; i < CAPACITY; i++) begin
			fill_key[i] = {$urandom(), 24'd0, i[7:0]};
			send(OP_ADD, fill_key[i], ID_W'(i));
		end
		send(OP_ADD, 64'hFFFF_0000_DEAD_BEEF, ID_W'(1));
		send(OP_LOOKUP, 64'd7, '0);
		drain();
		// clear the table
		for (int i = 0; i < CAPACITY; i++) send(OP_REMOVE, fill_key[i], ID_W'(i));

		// random: mostly operations on known keys
		for (int n = 0; n < 170; n++) begin
			r = $urandom_range(0, 99);
			if (n == 85) drain();
			if (key_pool.size() == 0 || r < 35) begin
				k = (r & 1) ? rand_key() : 64'($urandom_range(0, 63));
				id = ID_W'($urandom());
				key_pool.push_back(k);
				id_pool.push_back(id);
				send(OP_ADD, k, id);
			end else begin
				idx = $urandom_range(0, key_pool.size() - 1);
				if (r < 60) send(OP_LOOKUP, key_pool[idx], ID_W'($urandom()));
				else if (r < 80) begin
					send(OP_REMOVE, key_pool[idx], id_pool[idx]);
					key_pool.delete(idx);
					id_pool.delete(idx);
				end else if (r < 88) send(OP_REMOVE, key_pool[idx], ID_W'($urandom()));
				else if (r < 94) send(OP_ADD, key_pool[idx], ID_W'($urandom()));
				else send(2'($urandom_range(0, 3)), rand_key(), ID_W'($urandom()));
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
